[rtl/core/bdq_pkg.sv]
package bdq_pkg;

	// sizes
	localparam int DEPTH       = 64;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int REQ_W       = 3;
	localparam int POS_W       = 7;
	localparam int STAT_W      = 2;
	localparam int S_TDATA_W   = 32;
	localparam int S_TUSER_W   = 8;
	localparam int M_TDATA_W   = 16;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_SEARCH     = 3'd4
	} req_type_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// what every cell of the chain does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_SHR  = 2'd2,
		CELL_SHL  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   wdata;
	} cell_ctrl_t;

	// sequencer states
	typedef enum logic {
		S_IDLE   = 1'b0,
		S_SEARCH = 1'b1
	} state_t;

	// no match marker
	localparam logic [POS_W-1:0] POS_NONE = '1;

endpackage

[rtl/core/bdq_cell.sv]
module bdq_cell (
	input  logic                        clk,
	input  bdq_pkg::cell_ctrl_t         ctrl,
	input  logic                        sel,
	input  logic [bdq_pkg::DATA_W-1:0]  left,
	input  logic [bdq_pkg::DATA_W-1:0]  right,
	output logic [bdq_pkg::DATA_W-1:0]  value
);

	logic [bdq_pkg::DATA_W-1:0] value_q;

	// hold, load at the back slot, or take a neighbour's value
	always_ff @(posedge clk) begin
		case (ctrl.op)
			bdq_pkg::CELL_LOAD: begin
				if (sel) begin
					value_q <= ctrl.wdata;
				end
			end
			bdq_pkg::CELL_SHR: value_q <= left;
			bdq_pkg::CELL_SHL: value_q <= right;
			default: ;
		endcase
	end

	assign value = value_q;

endmodule

[rtl/core/bounded_deque_with_search_core.sv]
// push and pop requests give their result in the cycle after acceptance
// a search gives its result once the sequencer has stepped through every cell
// throughput: one push or pop per cycle while results are taken; a search holds
//   the block until the whole cell chain has rotated once past the comparator
//   at the front cell
// reset: count, sequencer and output valid clear; cell contents are not reset
module bounded_deque_with_search_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bdq_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] item_value
	input  logic [bdq_pkg::S_TUSER_W-1:0]    s_tuser,   // [2:0] req_type, rest zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bdq_pkg::M_TDATA_W-1:0]    m_tdata    // [6:0] position, [7] found,
	                                                    // [9:8] status, [10] is_empty
);

	localparam int DEPTH  = bdq_pkg::DEPTH;
	localparam int IDX_W  = bdq_pkg::IDX_W;
	localparam int CNT_W  = bdq_pkg::CNT_W;
	localparam int DATA_W = bdq_pkg::DATA_W;
	localparam int POS_W  = bdq_pkg::POS_W;

	bdq_pkg::state_t     state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    step_q, step_d;
	logic                found_q, found_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [DATA_W-1:0]   key_q, key_d;

	bdq_pkg::cell_ctrl_t cell_ctrl;
	logic [DATA_W-1:0]   cell_value [DEPTH];
	logic [DEPTH-1:0]    cell_sel;

	logic                out_valid_q;
	logic [POS_W-1:0]    out_pos_q, res_pos;
	logic                out_found_q, res_found;
	bdq_pkg::status_t    out_status_q, res_status;
	logic                out_empty_q;
	logic                res_load;

	bdq_pkg::req_type_t  req;
	logic                accept;
	logic                full;
	logic                empty;
	logic                match;
	logic                last_step;

	assign req      = bdq_pkg::req_type_t'(s_tuser[bdq_pkg::REQ_W-1:0]);
	assign s_tready = (state_q == bdq_pkg::S_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	// chain of cells, front entry in cell 0
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;

		if (g == 0) begin : g_first
			assign left_in = cell_ctrl.wdata;
		end else begin : g_mid_l
			assign left_in = cell_value[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_in = cell_value[0];
		end else begin : g_mid_r
			assign right_in = cell_value[g+1];
		end

		assign cell_sel[g] = (count_q == CNT_W'(g));

		bdq_cell u_cell (
			.clk   (clk),
			.ctrl  (cell_ctrl),
			.sel   (cell_sel[g]),
			.left  (left_in),
			.right (right_in),
			.value (cell_value[g])
		);
	end

	// search compare at the front cell while the ring rotates
	assign match     = (cell_value[0] == key_q) && (CNT_W'(step_q) < count_q) && !found_q;
	assign last_step = (step_q == IDX_W'(DEPTH - 1));

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q  <= step_d;
			found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		key_q <= key_d;
	end

	// next state, cell commands and result
	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		step_d          = step_q;
		found_d         = found_q;
		pos_d           = pos_q;
		key_d           = key_q;
		cell_ctrl.op    = bdq_pkg::CELL_HOLD;
		cell_ctrl.wdata = s_tdata[DATA_W-1:0];
		res_load        = 1'b0;
		res_pos         = bdq_pkg::POS_NONE;
		res_found       = 1'b0;
		res_status      = bdq_pkg::ST_DONE;

		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					case (req)
						bdq_pkg::REQ_PUSH_BACK: begin
							if (full) begin
								res_status = bdq_pkg::ST_FULL;
							end else begin
								cell_ctrl.op = bdq_pkg::CELL_LOAD;
								count_d      = count_q + 1'b1;
							end
						end
						bdq_pkg::REQ_PUSH_FRONT: begin
							if (full) begin
								res_status = bdq_pkg::ST_FULL;
							end else begin
								cell_ctrl.op = bdq_pkg::CELL_SHR;
								count_d      = count_q + 1'b1;
							end
						end
						bdq_pkg::REQ_POP_FRONT: begin
							if (empty) begin
								res_status = bdq_pkg::ST_EMPTY;
							end else begin
								cell_ctrl.op = bdq_pkg::CELL_SHL;
								count_d      = count_q - 1'b1;
							end
						end
						bdq_pkg::REQ_POP_BACK: begin
							if (empty) begin
								res_status = bdq_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						bdq_pkg::REQ_SEARCH: begin
							res_load = 1'b0;
							state_d  = bdq_pkg::S_SEARCH;
							step_d   = '0;
							found_d  = 1'b0;
							key_d    = s_tdata[DATA_W-1:0];
						end
						default: ;
					endcase
				end
			end
			bdq_pkg::S_SEARCH: begin
				cell_ctrl.op = bdq_pkg::CELL_SHL;
				step_d       = step_q + 1'b1;
				if (match) begin
					found_d = 1'b1;
					pos_d   = POS_W'(step_q);
				end
				if (last_step) begin
					state_d   = bdq_pkg::S_IDLE;
					step_d    = '0;
					res_load  = 1'b1;
					res_found = found_q || match;
					if (found_q) begin
						res_pos = pos_q;
					end else if (match) begin
						res_pos = POS_W'(step_q);
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_pos_q    <= res_pos;
			out_found_q  <= res_found;
			out_status_q <= res_status;
			out_empty_q  <= (count_d == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = bdq_pkg::M_TDATA_W'({out_empty_q, out_status_q, out_found_q, out_pos_q});

endmodule

[rtl/core/bdq_checker.sv]
module bdq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [bdq_pkg::S_TDATA_W-1:0]    s_tdata,
	input logic [bdq_pkg::S_TUSER_W-1:0]    s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bdq_pkg::M_TDATA_W-1:0]    m_tdata
);

	logic [bdq_pkg::POS_W-1:0]  position;
	logic                       found;
	logic [bdq_pkg::STAT_W-1:0] status;
	logic                       is_empty;
	logic                       not_search;

	assign position   = m_tdata[6:0];
	assign found      = m_tdata[7];
	assign status     = m_tdata[9:8];
	assign is_empty   = m_tdata[10];
	assign not_search = (s_tuser[bdq_pkg::REQ_W-1:0] != bdq_pkg::REQ_SEARCH);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// every request but a search answers on the next cycle
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && not_search |=> m_tvalid)
		else $error("push or pop result late");

	// a miss always reports no position
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !found |-> position == bdq_pkg::POS_NONE)
		else $error("position given without a match");

	// a match only on a completed request with entries held
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && found |-> status == bdq_pkg::ST_DONE && !is_empty)
		else $error("match reported with bad status or empty sequence");

	// a dropped push means the sequence is full, so not empty
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == bdq_pkg::ST_FULL |-> !is_empty)
		else $error("full flag on an empty sequence");

endmodule

bind bounded_deque_with_search_core bdq_checker u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[dv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	// cycles with no handshake on either side before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1250;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic              found;
		logic [STAT_W-1:0] status;
		logic              is_empty;
	} deque_result_t;

	// mirror of the deque contents and the results still owed by the block
	class deque_tracker;
		logic [DATA_W-1:0] slots [DEPTH];
		int unsigned       head = 0;
		int unsigned       held = 0;
		deque_result_t     awaited_results [$];
		int                mismatches = 0;

		// work out the result of an accepted request and update the mirror
		function void note_request(logic [REQ_W-1:0] rq, logic [DATA_W-1:0] v);
			deque_result_t r;
			int unsigned   i;
			r.position = POS_NONE;
			r.found    = 1'b0;
			r.status   = ST_DONE;
			case (rq)
				REQ_PUSH_BACK: begin
					if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slots[(head + held) % DEPTH] = v;
						held++;
					end
				end
				REQ_PUSH_FRONT: begin
					if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						head = (head == 0) ? DEPTH - 1 : head - 1;
						slots[head] = v;
						held++;
					end
				end
				REQ_POP_FRONT: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						head = (head + 1) % DEPTH;
						held--;
					end
				end
				REQ_POP_BACK: begin
					if (held == 0)
						r.status = ST_EMPTY;
					else
						held--;
				end
				REQ_SEARCH: begin
					// first match from the front wins
					for (i = 0; i < held && !r.found; i++) begin
						if (slots[(head + i) % DEPTH] == v) begin
							r.position = i[POS_W-1:0];
							r.found    = 1'b1;
						end
					end
				end
				default: ;
			endcase
			r.is_empty = (held == 0);
			awaited_results.push_back(r);
		endfunction

		// compare one result with the oldest one owed
		function void check_result(logic [M_TDATA_W-1:0] d);
			deque_result_t want;
			if (awaited_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result %h with nothing awaited", $realtime, d);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			if (d[6:0] !== want.position || d[7] !== want.found ||
			    d[9:8] !== want.status || d[10] !== want.is_empty) begin
				if (mismatches < 10)
					$display("%0t: pos/found/status/empty expected %h/%b/%0d/%b got %h/%b/%0d/%b",
						$realtime, want.position, want.found, want.status, want.is_empty,
						d[6:0], d[7], d[9:8], d[10]);
				mismatches++;
			end
		endfunction

		function int owed();
			return awaited_results.size();
		endfunction

		// some value currently held, so that searches hit at any depth
		function logic [DATA_W-1:0] held_value(int unsigned k);
			if (held == 0)
				return $urandom();
			return slots[(head + k % held) % DEPTH];
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	logic                 calm = 1'b0;
	int                   quiet_cycles = 0;
	deque_tracker         tracker = new();

	bounded_deque_with_search_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	always @(negedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 21);
	end

	// observe both handshakes, results first since they belong to older requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata);
			if (s_tvalid && s_tready)
				tracker.note_request(s_tuser[REQ_W-1:0], s_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// present one request, with random gaps in front of it
	task automatic send_request(input logic [REQ_W-1:0] rq, input logic [DATA_W-1:0] v);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(0, 99) < 21) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= {{(S_TUSER_W-REQ_W){1'b0}}, rq};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0:       return 32'h8000_0000;
				1:       return 32'h7FFF_FFFF;
				2:       return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r <= 4)
			return $urandom_range(0, 15);
		return $urandom();
	endfunction

	// request mix per phase: 0 filling, 1 draining, 2 mixed
	function automatic logic [REQ_W-1:0] pick_request(int phase);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return REQ_W'($urandom_range(5, 7));
		case (phase)
			0: begin
				if (r < 85) return (r[0]) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
				if (r < 95) return REQ_SEARCH;
				return (r[0]) ? REQ_POP_FRONT : REQ_POP_BACK;
			end
			1: begin
				if (r < 80) return (r[0]) ? REQ_POP_FRONT : REQ_POP_BACK;
				if (r < 95) return REQ_SEARCH;
				return (r[0]) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			end
			default: begin
				if (r < 50) return (r[0]) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
				if (r < 75) return (r[0]) ? REQ_POP_FRONT : REQ_POP_BACK;
				return REQ_SEARCH;
			end
		endcase
	endfunction

	initial begin
		int                sent;
		int                phase;
		int                span;
		logic [REQ_W-1:0]  rq;
		logic [DATA_W-1:0] v;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty deque, unused codes
		send_request(REQ_SEARCH, 32'h0000_0000);
		send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
		send_request(REQ_POP_BACK, 32'h0000_0000);
		send_request(3'd5, 32'h1234_5678);
		send_request(3'd6, 32'h8000_0000);
		send_request(3'd7, 32'h7FFF_FFFF);
		// extreme values at both ends, then searched
		send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
		send_request(REQ_PUSH_BACK, 32'h8000_0000);
		send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
		send_request(REQ_PUSH_FRONT, 32'h0000_0000);
		send_request(REQ_SEARCH, 32'h8000_0000);
		send_request(REQ_SEARCH, 32'h0000_0000);
		send_request(REQ_SEARCH, 32'h1234_5678);
		// drain down to a lone entry and remove it from either end
		send_request(REQ_POP_BACK, 32'h0);
		send_request(REQ_POP_FRONT, 32'h0);
		send_request(REQ_POP_BACK, 32'h0);
		send_request(REQ_POP_FRONT, 32'h0);
		send_request(REQ_PUSH_FRONT, 32'd5);
		send_request(REQ_POP_BACK, 32'h0);
		send_request(REQ_PUSH_BACK, 32'd5);
		send_request(REQ_POP_FRONT, 32'h0);
		// duplicates: first from the front is reported
		send_request(REQ_PUSH_BACK, 32'd7);
		send_request(REQ_PUSH_BACK, 32'd7);
		send_request(REQ_SEARCH, 32'd7);
		send_request(REQ_POP_FRONT, 32'h0);
		send_request(REQ_POP_BACK, 32'h0);

		// random phases, opening with a filling phase
		sent  = 0;
		phase = 0;
		span  = 80;
		while (sent < RANDOM_ITEMS) begin
			repeat (span) begin
				calm = (sent >= 500 && sent < 650);
				rq = pick_request(phase);
				if (rq == REQ_SEARCH && $urandom_range(0, 1) == 1)
					v = tracker.held_value($urandom());
				else
					v = pick_value();
				send_request(rq, v);
				sent++;
			end
			phase = $urandom_range(0, 2);
			span  = $urandom_range(20, 90);
		end
		calm = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		// let the last results drain, then a short tail
		while (tracker.owed() != 0)
			@(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.owed() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
